// ----- rtl/core/plbu_pkg.sv -----
package plbu_pkg;

  localparam int MAX_DEPTH   = 10;
  localparam int INSTRUMENTS = 256;
  localparam int NLV         = 2 * MAX_DEPTH;
  localparam int CW          = $clog2(MAX_DEPTH + 1);
  localparam int KW          = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int FW          = $clog2(NLV);

  localparam logic [1:0] CMD_ENTRY  = 2'd0;
  localparam logic [1:0] CMD_DEFINE = 2'd1;
  localparam logic [1:0] CMD_RESET  = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic [2:0] TY_BID   = 3'd0;
  localparam logic [2:0] TY_OFFER = 3'd1;
  localparam logic [2:0] TY_RESET = 3'd3;

  localparam logic [2:0] ACT_NEW    = 3'd0;
  localparam logic [2:0] ACT_CHANGE = 3'd1;
  localparam logic [2:0] ACT_DELETE = 3'd2;
  localparam logic [2:0] ACT_THRU   = 3'd3;
  localparam logic [2:0] ACT_FROM   = 3'd4;
  localparam logic [2:0] ACT_OVLY   = 3'd5;

  localparam logic [2:0] ST_APPLIED = 3'd0;
  localparam logic [2:0] ST_STALE   = 3'd1;
  localparam logic [2:0] ST_SKIPPED = 3'd2;
  localparam logic [2:0] ST_GAP     = 3'd3;
  localparam logic [2:0] ST_BOOKERR = 3'd4;
  localparam logic [2:0] ST_IGNORED = 3'd5;
  localparam logic [2:0] ST_DONE    = 3'd6;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic [1:0]         command;
    logic [7:0]         instrument;
    logic [31:0]        sequence_number;
    logic [2:0]         entry_type;
    logic [2:0]         update_action;
    logic [7:0]         price_level;
    logic signed [63:0] price;
    logic               price_valid;
    logic signed [31:0] quantity;
    logic               size_present;
    logic [7:0]         depth_setting;
  } item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic               level_valid;
    logic               side;
    logic signed [63:0] level_price;
    logic [30:0]        level_qty;
    logic               is_recovering;
    logic               last;
  } result_t;

  typedef struct packed {
    logic signed [63:0] px;
    logic [30:0]        qty;
  } lvl_t;

  typedef struct packed {
    logic [CW-1:0] cnt_b;
    logic [CW-1:0] cnt_a;
    logic [31:0]   seq;
    logic          unk;
    logic          rec;
    logic [CW-1:0] depth;
  } meta_t;

  typedef struct packed {
    logic cap;
    logic exec;
    logic step;
  } ctrl_cmd_t;

  typedef struct packed {
    logic can_step;
    logic final_step;
  } dp_sts_t;

  function automatic logic beats(input logic sd, input logic signed [63:0] a,
                                 input logic signed [63:0] b);
    return sd ? (a < b) : (a > b);
  endfunction

endpackage

// ----- rtl/core/plbu_ifs.sv -----
interface plbu_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic [7:0]         instrument;
  logic [31:0]        sequence_number;
  logic [2:0]         entry_type;
  logic [2:0]         update_action;
  logic [7:0]         price_level;
  logic signed [63:0] price;
  logic               price_valid;
  logic signed [31:0] quantity;
  logic               size_present;
  logic [7:0]         depth_setting;
  modport source(output valid, command, instrument, sequence_number, entry_type,
                 update_action, price_level, price, price_valid, quantity,
                 size_present, depth_setting, input ready);
  modport sink(input valid, command, instrument, sequence_number, entry_type,
               update_action, price_level, price, price_valid, quantity,
               size_present, depth_setting, output ready);
endinterface

interface plbu_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic               level_valid;
  logic               side;
  logic signed [63:0] level_price;
  logic [30:0]        level_qty;
  logic               is_recovering;
  logic               last;
  modport source(output valid, status, level_valid, side, level_price, level_qty,
                 is_recovering, last, input ready);
  modport sink(input valid, status, level_valid, side, level_price, level_qty,
               is_recovering, last, output ready);
endinterface

interface plbu_cfg_if;
  logic valid;
  logic ready;
  logic new_starts_recovering;
  modport source(output valid, new_starts_recovering, input ready);
  modport sink(input valid, new_starts_recovering, output ready);
endinterface

// ----- rtl/core/price_level_book_update_top.sv -----
// Channel   Role    Carries
// book_in   sink    one book entry or command per transfer
// book_out  source  one result per transfer, last marks the end of an item
// cfg       sink    new_starts_recovering write, always ready
//
// Each item: capture with row and state read, execute with write back, then
// 1 to 20 result transfers, one per cycle unless book_out stalls.
// Synchronous reset clears control; book rows need no clearing pass.
// A stalled book_out holds the result register and the next item waits.
module price_level_book_update_top (
  input logic         clk,
  input logic         rst,
  plbu_in_if.sink     book_in,
  plbu_out_if.source  book_out,
  plbu_cfg_if.sink    cfg
);
  import plbu_pkg::*;

  item_t     item;
  result_t   res;
  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  assign item.command         = book_in.command;
  assign item.instrument      = book_in.instrument;
  assign item.sequence_number = book_in.sequence_number;
  assign item.entry_type      = book_in.entry_type;
  assign item.update_action   = book_in.update_action;
  assign item.price_level     = book_in.price_level;
  assign item.price           = book_in.price;
  assign item.price_valid     = book_in.price_valid;
  assign item.quantity        = book_in.quantity;
  assign item.size_present    = book_in.size_present;
  assign item.depth_setting   = book_in.depth_setting;

  assign cfg.ready = 1'b1;

  plbu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (book_in.valid),
    .in_ready (book_in.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  plbu_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cfg_we    (cfg.valid),
    .cfg_nsr   (cfg.new_starts_recovering),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (book_out.valid),
    .out_ready (book_out.ready),
    .res       (res)
  );

  assign book_out.status        = res.status;
  assign book_out.level_valid   = res.level_valid;
  assign book_out.side          = res.side;
  assign book_out.level_price   = res.level_price;
  assign book_out.level_qty     = res.level_qty;
  assign book_out.is_recovering = res.is_recovering;
  assign book_out.last          = res.last;

endmodule

// ----- rtl/core/plbu_dp.sv -----
module plbu_dp (
  input  logic                clk,
  input  logic                rst,
  input  plbu_pkg::item_t     item,
  input  logic                cfg_we,
  input  logic                cfg_nsr,
  input  plbu_pkg::ctrl_cmd_t cmd,
  output plbu_pkg::dp_sts_t   sts,
  output logic                out_valid,
  input  logic                out_ready,
  output plbu_pkg::result_t   res
);
  import plbu_pkg::*;

  lvl_t [NLV-1:0] book_mem [INSTRUMENTS];
  meta_t          meta_mem [INSTRUMENTS];
  logic [INSTRUMENTS-1:0] meta_vld;

  item_t          in_r;
  lvl_t [NLV-1:0] row_r;
  meta_t          meta_rd;
  logic           vld_rd;
  logic           nsr;

  meta_t          meta;
  meta_t          nx_meta;
  lvl_t [NLV-1:0] nx_row;
  logic [NLV-1:0] nx_mask;
  logic           nx_extra;
  lvl_t           nx_lvl;
  logic [2:0]     nx_status;

  logic [NLV-1:0] em_mask;
  logic           em_extra;
  lvl_t           em_lvl;
  logic           em_side;
  logic [2:0]     em_status;
  logic           em_rec;
  logic [FW-1:0]  sel;
  logic           fin;

  always_comb begin
    meta.cnt_b = '0;
    meta.cnt_a = '0;
    meta.seq   = '0;
    meta.unk   = 1'b0;
    meta.rec   = 1'b0;
    meta.depth = CW'(MAX_DEPTH);
    if (vld_rd) begin
      meta = meta_rd;
    end
  end

  always_comb begin : exec_logic
    logic          sd;
    logic [CW-1:0] cnt;
    logic [CW-1:0] kc;
    logic [CW-1:0] nn;
    logic [KW-1:0] k;
    logic          lvl_ok;
    logic          szok;
    logic          ord_prev;
    logic          ord_nx;
    logic          ord_nx2;
    logic          ok;
    logic          go;
    lvl_t          op [MAX_DEPTH];
    lvl_t          ns [MAX_DEPTH];
    lvl_t          prv;
    lvl_t          atk;
    logic [MAX_DEPTH-1:0] msk;
    logic [CW-1:0] ncnt;
    logic [7:0]    dset;

    sd       = in_r.entry_type[0];
    cnt      = sd ? meta.cnt_a : meta.cnt_b;
    k        = KW'(in_r.price_level - 8'd1);
    kc       = CW'(k);
    lvl_ok   = (in_r.price_level != 8'd0) && (in_r.price_level <= 8'(meta.depth));
    szok     = in_r.price_valid && in_r.size_present && !in_r.quantity[31];
    nx_lvl.px  = in_r.price;
    nx_lvl.qty = in_r.quantity[30:0];
    prv      = '0;
    atk      = '0;
    msk      = '0;
    ok       = 1'b0;
    go       = 1'b0;
    ncnt     = cnt;
    nx_meta  = meta;
    nx_row   = row_r;
    nx_mask  = '0;
    nx_extra = 1'b0;
    nx_status = ST_IGNORED;
    dset     = in_r.depth_setting;
    nn       = '0;

    for (int j = 0; j < MAX_DEPTH; j++) begin
      op[j] = sd ? row_r[MAX_DEPTH + j] : row_r[j];
      ns[j] = op[j];
    end
    for (int j = 0; j < MAX_DEPTH; j++) begin
      if (j + 1 == int'(k)) begin
        prv = op[j];
      end
      if (j == int'(k)) begin
        atk = op[j];
      end
    end
    ord_prev = (k == '0) || beats(sd, prv.px, in_r.price);
    ord_nx   = !(kc < cnt) || beats(sd, in_r.price, atk.px);
    ord_nx2  = !((kc + CW'(1)) < cnt);
    for (int j = 0; j < MAX_DEPTH; j++) begin
      if (j == int'(k) + 1 && !ord_nx2) begin
        ord_nx2 = beats(sd, in_r.price, op[j].px);
      end
    end

    case (in_r.update_action)
      ACT_NEW: begin
        ok = szok && (kc <= cnt) && ord_prev && ord_nx;
        if (cnt >= meta.depth) begin
          msk[meta.depth - CW'(1)] = 1'b1;
          ncnt = meta.depth;
        end else begin
          ncnt = cnt + CW'(1);
        end
        for (int j = 0; j < MAX_DEPTH; j++) begin
          if (j == int'(k)) begin
            ns[j] = nx_lvl;
          end else if (j > int'(k)) begin
            ns[j] = op[j - 1];
          end
        end
        nx_extra = 1'b1;
      end
      ACT_CHANGE: begin
        ok = szok && (kc < cnt) && (atk.px == in_r.price);
        for (int j = 0; j < MAX_DEPTH; j++) begin
          if (j == int'(k)) begin
            ns[j].qty = nx_lvl.qty;
          end
        end
        nx_extra = 1'b1;
      end
      ACT_DELETE: begin
        ok = (kc < cnt) && (!in_r.price_valid || (in_r.price == atk.px));
        msk[k] = 1'b1;
        for (int j = 0; j < MAX_DEPTH - 1; j++) begin
          if (j >= int'(k)) begin
            ns[j] = op[j + 1];
          end
        end
        ncnt = cnt - CW'(1);
      end
      ACT_THRU: begin
        ok = 1'b1;
        nn = (in_r.price_level < 8'(cnt)) ? CW'(in_r.price_level) : cnt;
        for (int j = 0; j < MAX_DEPTH; j++) begin
          msk[j] = (j < int'(nn));
          for (int i = 0; i < MAX_DEPTH; i++) begin
            if (i == j + int'(nn)) begin
              ns[j] = op[i];
            end
          end
        end
        ncnt = cnt - nn;
      end
      ACT_FROM: begin
        ok = 1'b1;
        for (int j = 0; j < MAX_DEPTH; j++) begin
          msk[j] = (j >= int'(k)) && (j < int'(cnt));
        end
        if (kc < cnt) begin
          ncnt = kc;
        end
      end
      ACT_OVLY: begin
        ok = szok && (kc <= cnt) && ord_prev && ord_nx2;
        if (kc == cnt) begin
          ncnt = cnt + CW'(1);
        end else if (atk.px != in_r.price) begin
          msk[k] = 1'b1;
        end
        for (int j = 0; j < MAX_DEPTH; j++) begin
          if (j == int'(k)) begin
            ns[j] = nx_lvl;
          end
        end
        nx_extra = 1'b1;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
    ok = ok && lvl_ok;

    case (in_r.command)
      CMD_DEFINE: begin
        if (dset == 8'd0) begin
          dset = 8'd1;
        end
        if (dset > 8'(MAX_DEPTH)) begin
          dset = 8'(MAX_DEPTH);
        end
        nx_meta.depth = CW'(dset);
        nx_meta.cnt_b = '0;
        nx_meta.cnt_a = '0;
        nx_meta.seq   = '0;
        nx_meta.unk   = 1'b0;
        nx_meta.rec   = nsr;
        nx_status     = ST_DONE;
        nx_extra      = 1'b0;
      end
      CMD_RESET: begin
        nx_meta.cnt_b = '0;
        nx_meta.cnt_a = '0;
        nx_meta.seq   = '0;
        nx_meta.unk   = 1'b1;
        nx_meta.rec   = 1'b0;
        nx_status     = ST_DONE;
        nx_extra      = 1'b0;
      end
      CMD_ENTRY: begin
        if (meta.rec) begin
          nx_status = ST_SKIPPED;
        end else if (meta.unk) begin
          nx_meta.unk = 1'b0;
          nx_meta.seq = in_r.sequence_number;
          go = 1'b1;
        end else if (in_r.sequence_number <= meta.seq) begin
          nx_status = ST_STALE;
        end else if (in_r.sequence_number != meta.seq + 32'd1) begin
          nx_meta.rec = 1'b1;
          nx_status   = ST_GAP;
        end else begin
          nx_meta.seq = in_r.sequence_number;
          go = 1'b1;
        end
        if (!go) begin
          nx_extra = 1'b0;
        end else if (in_r.entry_type == TY_RESET) begin
          for (int j = 0; j < MAX_DEPTH; j++) begin
            nx_mask[j]             = (j < int'(meta.cnt_b));
            nx_mask[MAX_DEPTH + j] = (j < int'(meta.cnt_a));
          end
          nx_meta.cnt_b = '0;
          nx_meta.cnt_a = '0;
          nx_status     = ST_APPLIED;
          nx_extra      = 1'b0;
        end else if (in_r.entry_type != TY_BID && in_r.entry_type != TY_OFFER) begin
          nx_status = ST_IGNORED;
          nx_extra  = 1'b0;
        end else if (!ok) begin
          nx_meta.rec = 1'b1;
          nx_status   = ST_BOOKERR;
          nx_extra    = 1'b0;
        end else begin
          nx_status = ST_APPLIED;
          if (sd) begin
            nx_meta.cnt_a = ncnt;
            nx_mask[NLV-1:MAX_DEPTH] = msk;
          end else begin
            nx_meta.cnt_b = ncnt;
            nx_mask[MAX_DEPTH-1:0] = msk;
          end
          for (int j = 0; j < MAX_DEPTH; j++) begin
            if (sd) begin
              nx_row[MAX_DEPTH + j] = ns[j];
            end else begin
              nx_row[j] = ns[j];
            end
          end
        end
      end
      default: begin
        nx_status = ST_IGNORED;
        nx_extra  = 1'b0;
      end
    endcase
  end

  always_comb begin
    sel = '0;
    for (int i = NLV - 1; i >= 0; i--) begin
      if (em_mask[i]) begin
        sel = FW'(i);
      end
    end
    if (em_mask != '0) begin
      fin = ((em_mask & (em_mask - NLV'(1))) == '0) && !em_extra;
    end else begin
      fin = 1'b1;
    end
    sts.can_step   = !out_valid || out_ready;
    sts.final_step = fin;
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      row_r   <= book_mem[item.instrument];
      meta_rd <= meta_mem[item.instrument];
      in_r    <= item;
    end
    if (cmd.exec) begin
      book_mem[in_r.instrument] <= nx_row;
      meta_mem[in_r.instrument] <= nx_meta;
      em_lvl    <= nx_lvl;
      em_side   <= in_r.entry_type[0];
      em_status <= nx_status;
      em_rec    <= nx_meta.rec;
    end
    if (cmd.step) begin
      res.status        <= em_status;
      res.is_recovering <= em_rec;
      res.last          <= fin;
      if (em_mask != '0) begin
        res.level_valid <= 1'b1;
        res.side        <= (int'(sel) >= MAX_DEPTH);
        res.level_price <= row_r[sel].px;
        res.level_qty   <= '0;
      end else if (em_extra) begin
        res.level_valid <= 1'b1;
        res.side        <= em_side;
        res.level_price <= em_lvl.px;
        res.level_qty   <= em_lvl.qty;
      end else begin
        res.level_valid <= 1'b0;
        res.side        <= 1'b0;
        res.level_price <= '0;
        res.level_qty   <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      meta_vld  <= '0;
      vld_rd    <= 1'b0;
      nsr       <= 1'b0;
      out_valid <= 1'b0;
      em_mask   <= '0;
      em_extra  <= 1'b0;
    end else begin
      if (cfg_we) begin
        nsr <= cfg_nsr;
      end
      if (cmd.cap) begin
        vld_rd <= meta_vld[item.instrument];
      end
      if (cmd.exec) begin
        meta_vld[in_r.instrument] <= 1'b1;
        em_mask  <= nx_mask;
        em_extra <= nx_extra;
      end
      if (cmd.step) begin
        out_valid <= 1'b1;
        if (em_mask != '0) begin
          em_mask[sel] <= 1'b0;
        end else begin
          em_extra <= 1'b0;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/core/plbu_ctrl.sv -----
module plbu_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  plbu_pkg::dp_sts_t   sts,
  output plbu_pkg::ctrl_cmd_t cmd
);
  import plbu_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (sts.can_step && sts.final_step) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.cap  = in_valid;
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
      end
      S_EMIT: begin
        cmd.step = sts.can_step;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  a_cap_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.cap |=> state == S_EXEC) else $error("capture not followed by execute");
  a_step_room: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> sts.can_step) else $error("transfer step into full output");
  a_final_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.step && sts.final_step) |=> state == S_IDLE) else $error("no return to idle");

endmodule
